/* rtl/fbm_pkg.sv */
// Package for the fractal value-noise height sampler.
// Holds constants, the register map, the controller state and op types and
// the command/status structs. Depends on nothing.
package fbm_pkg;

   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W       = 24 + MAX_OCTAVES;
   localparam int DIV_CNT_W   = $clog2(SUM_W);
   localparam int STEP_W      = 3;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [31:0] HASH_CX   = 32'd73856093;
   localparam logic [31:0] HASH_CZ   = 32'd19349663;
   localparam logic [31:0] HASH_CS   = 32'd83492791;
   localparam logic [31:0] MIX_M1    = 32'h7feb352d;
   localparam logic [31:0] MIX_M2    = 32'h846ca68b;
   localparam logic [31:0] SEED_STEP = 32'd101;
   localparam logic [63:0] OFS_X     = 64'h0000_0011_2147_AE14;
   localparam logic [63:0] OFS_Z     = 64'h0000_001F_B5C2_8F5C;
   localparam logic [24:0] ONE_Q24   = 25'h100_0000;
   localparam logic [25:0] THREE_Q24 = 26'h300_0000;
   localparam logic [23:0] MASK24    = 24'hFF_FFFF;

   localparam logic [23:0] NOISE_FREQ_RST   = 24'd4096;
   localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd4;
   localparam logic [31:0] NOISE_SEED_RST   = 32'd0;
   localparam logic [15:0] HEIGHT_SCALE_RST = 16'd6144;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_FREQ   = 8'd0,
      CSR_OCTAVE_COUNT = 8'd1,
      CSR_NOISE_SEED   = 8'd2,
      CSR_HEIGHT_SCALE = 8'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_OCT,
      ST_DIV,
      ST_SHP1,
      ST_SHP2,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BASE,
      OP_P0,
      OP_P1,
      OP_P2,
      OP_P3,
      OP_P4,
      OP_P5,
      OP_DIVSTEP,
      OP_SHP1,
      OP_SHP2,
      OP_OUT,
      OP_ZERO
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [OCT_W-1:0] oct_num;
      logic             out_free;
   } status_type;

endpackage

/* rtl/fbm_if.sv */
// Channel interfaces: coordinate requests, height responses, register writes.
// Depends on fbm_pkg.
interface fbm_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] world_x;
   logic signed [31:0] world_z;
   modport source(output valid, world_x, world_z, input ready);
   modport sink(input valid, world_x, world_z, output ready);
endinterface

interface fbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] height;
   modport source(output valid, height, input ready);
   modport sink(input valid, height, output ready);
endinterface

interface fbm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fbm_pkg::CSR_IDX_W-1:0]    index;
   logic [fbm_pkg::CSR_DATA_W-1:0]   data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* rtl/fbm_ctrl.sv */
// Sequencer for the height sampler: walks octaves, divider bits and shaping.
// Issues one op per cycle, stalled while output is full. Depends on fbm_pkg.
module fbm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fbm_pkg::status_type status,
   output fbm_pkg::cmd_type    cmd
);

   fbm_pkg::state_type             state_ff, state_in;
   logic [fbm_pkg::OCT_W-1:0]      oct_ff, oct_in;
   logic [fbm_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [fbm_pkg::DIV_CNT_W-1:0]  div_ff, div_in;
   logic                           zero_ff, zero_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbm_pkg::ST_IDLE;
         oct_ff   <= '0;
         step_ff  <= '0;
         div_ff   <= '0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         oct_ff   <= oct_in;
         step_ff  <= step_in;
         div_ff   <= div_in;
         zero_ff  <= zero_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      oct_in    = oct_ff;
      step_in   = step_ff;
      div_in    = div_ff;
      zero_in   = zero_ff;
      req_ready = 1'b0;
      cmd.op    = fbm_pkg::OP_NONE;
      case (state_ff)
         fbm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op  = fbm_pkg::OP_LOAD;
               oct_in  = '0;
               step_in = '0;
               div_in  = '0;
               zero_in = (status.oct_num == '0);
               state_in = (status.oct_num == '0) ? fbm_pkg::ST_FIN : fbm_pkg::ST_BASE;
            end
         end
         fbm_pkg::ST_BASE: begin
            cmd.op   = fbm_pkg::OP_BASE;
            state_in = fbm_pkg::ST_OCT;
         end
         fbm_pkg::ST_OCT: begin
            case (step_ff)
               3'd0:    cmd.op = fbm_pkg::OP_P0;
               3'd1:    cmd.op = fbm_pkg::OP_P1;
               3'd2:    cmd.op = fbm_pkg::OP_P2;
               3'd3:    cmd.op = fbm_pkg::OP_P3;
               3'd4:    cmd.op = fbm_pkg::OP_P4;
               3'd5:    cmd.op = fbm_pkg::OP_P5;
               default: cmd.op = fbm_pkg::OP_NONE;
            endcase
            if (step_ff == 3'd5) begin
               step_in = '0;
               if ((oct_ff + fbm_pkg::OCT_W'(1)) == status.oct_num) begin
                  state_in = fbm_pkg::ST_DIV;
               end else begin
                  oct_in = oct_ff + fbm_pkg::OCT_W'(1);
               end
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         fbm_pkg::ST_DIV: begin
            cmd.op = fbm_pkg::OP_DIVSTEP;
            if (div_ff == fbm_pkg::DIV_CNT_W'(fbm_pkg::SUM_W - 1)) begin
               state_in = fbm_pkg::ST_SHP1;
            end else begin
               div_in = div_ff + fbm_pkg::DIV_CNT_W'(1);
            end
         end
         fbm_pkg::ST_SHP1: begin
            cmd.op   = fbm_pkg::OP_SHP1;
            state_in = fbm_pkg::ST_SHP2;
         end
         fbm_pkg::ST_SHP2: begin
            cmd.op   = fbm_pkg::OP_SHP2;
            state_in = fbm_pkg::ST_FIN;
         end
         fbm_pkg::ST_FIN: begin
            if (status.out_free) begin
               cmd.op   = zero_ff ? fbm_pkg::OP_ZERO : fbm_pkg::OP_OUT;
               state_in = fbm_pkg::ST_IDLE;
            end
         end
         default: state_in = fbm_pkg::ST_IDLE;
      endcase
   end

endmodule

/* rtl/fbm_dp.sv */
// Datapath: config registers, lattice coordinates, hash/fade/lerp units,
// octave accumulator, restoring divider, shaping and output register.
// Depends on fbm_pkg.
module fbm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fbm_pkg::cmd_type                      cmd,
   output fbm_pkg::status_type                   status,
   input  logic signed [31:0]                    req_world_x,
   input  logic signed [31:0]                    req_world_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [23:0]                           rsp_height,
   input  logic                                  csr_valid,
   input  logic [fbm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fbm_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int MO = fbm_pkg::MAX_OCTAVES;
   localparam int SW = fbm_pkg::SUM_W;

   // config
   logic [23:0] freq_ff;
   logic [3:0]  oct_cnt_ff;
   logic [31:0] seed_ff;
   logic [15:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff    <= fbm_pkg::NOISE_FREQ_RST;
         oct_cnt_ff <= fbm_pkg::OCTAVE_COUNT_RST;
         seed_ff    <= fbm_pkg::NOISE_SEED_RST;
         scale_ff   <= fbm_pkg::HEIGHT_SCALE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            fbm_pkg::CSR_NOISE_FREQ:   freq_ff    <= csr_data[23:0];
            fbm_pkg::CSR_OCTAVE_COUNT: oct_cnt_ff <= csr_data[3:0];
            fbm_pkg::CSR_NOISE_SEED:   seed_ff    <= csr_data[31:0];
            fbm_pkg::CSR_HEIGHT_SCALE: scale_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [fbm_pkg::OCT_W-1:0] k_eff;
   assign k_eff = (32'(oct_cnt_ff) > 32'(MO)) ? fbm_pkg::OCT_W'(MO)
                                              : fbm_pkg::OCT_W'(oct_cnt_ff);

   // payload registers
   logic signed [31:0] wx_ff, wz_ff;
   logic [63:0]        bsh_x_ff, bsh_z_ff, ofs_x_ff, ofs_z_ff, px_ff, pz_ff;
   logic [31:0]        seed_o_ff, hx_ff, hz_ff, hs_ff;
   logic [23:0]        tx2_ff, tz2_ff, fx_ff, fz_ff, a_ff, b_ff;
   logic [31:0]        m1_ff [4];
   logic [31:0]        m2_ff [4];
   logic [SW-1:0]      sum_ff;
   logic [MO-1:0]      rem_ff;
   logic [23:0]        h_ff, t2h_ff, shaped_ff, height_ff;
   logic               valid_ff;

   // base coordinate products
   logic signed [56:0] prod_x, prod_z;
   assign prod_x = wx_ff * $signed({1'b0, freq_ff});
   assign prod_z = wz_ff * $signed({1'b0, freq_ff});

   // lattice indices and fractions
   logic [31:0] ix, iz;
   logic [23:0] tx, tz;
   logic [47:0] sqx, sqz;
   logic [25:0] kx, kz;
   logic [49:0] fpx, fpz;
   assign ix  = px_ff[63:32];
   assign iz  = pz_ff[63:32];
   assign tx  = px_ff[31:8];
   assign tz  = pz_ff[31:8];
   assign sqx = tx * tx;
   assign sqz = tz * tz;
   assign kx  = fbm_pkg::THREE_Q24 - {1'b0, tx, 1'b0};
   assign kz  = fbm_pkg::THREE_Q24 - {1'b0, tz, 1'b0};
   assign fpx = tx2_ff * kx;
   assign fpz = tz2_ff * kz;

   // corner hashes, index = {zi, xi}
   logic [31:0] key [4];
   logic [31:0] v1  [4];
   logic [31:0] v2  [4];
   logic [23:0] cv  [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         key[i] = (i[0] ? hx_ff + fbm_pkg::HASH_CX : hx_ff)
                ^ (i[1] ? hz_ff + fbm_pkg::HASH_CZ : hz_ff) ^ hs_ff;
         v1[i]  = key[i] ^ (key[i] >> 16);
         v2[i]  = m1_ff[i] ^ (m1_ff[i] >> 15);
         cv[i]  = m2_ff[i][23:0] ^ {8'd0, m2_ff[i][31:16]};
      end
   end

   // lerps
   logic [24:0] omfx, omfz;
   logic [49:0] lerp_a, lerp_b, lerp_n;
   assign omfx   = fbm_pkg::ONE_Q24 - {1'b0, fx_ff};
   assign omfz   = fbm_pkg::ONE_Q24 - {1'b0, fz_ff};
   assign lerp_a = 50'(cv[0]) * 50'(omfx) + 50'(cv[1]) * 50'(fx_ff);
   assign lerp_b = 50'(cv[2]) * 50'(omfx) + 50'(cv[3]) * 50'(fx_ff);
   assign lerp_n = 50'(a_ff) * 50'(omfz) + 50'(b_ff) * 50'(fz_ff);

   // divider by 2^k - 1
   logic [MO-1:0] dvs;
   logic [MO:0]   rem_sh, rem_dif;
   logic          ge;
   assign dvs     = {MO{1'b1}} >> (fbm_pkg::OCT_W'(MO) - k_eff);
   assign rem_sh  = {rem_ff, sum_ff[SW-1]};
   assign rem_dif = rem_sh - {1'b0, dvs};
   assign ge      = (rem_sh >= {1'b0, dvs});

   // shaping
   logic [23:0] hq;
   logic [47:0] sqh;
   logic [25:0] kh;
   logic [49:0] fph;
   logic [39:0] scl;
   assign hq  = (sum_ff[SW-1:24] != '0) ? fbm_pkg::MASK24 : sum_ff[23:0];
   assign sqh = hq * hq;
   assign kh  = fbm_pkg::THREE_Q24 - {1'b0, h_ff, 1'b0};
   assign fph = t2h_ff * kh;
   assign scl = shaped_ff * scale_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         fbm_pkg::OP_LOAD: begin
            wx_ff     <= req_world_x;
            wz_ff     <= req_world_z;
            ofs_x_ff  <= '0;
            ofs_z_ff  <= '0;
            seed_o_ff <= seed_ff;
            sum_ff    <= '0;
            rem_ff    <= '0;
         end
         fbm_pkg::OP_BASE: begin
            bsh_x_ff <= {{7{prod_x[56]}}, prod_x};
            bsh_z_ff <= {{7{prod_z[56]}}, prod_z};
         end
         fbm_pkg::OP_P0: begin
            px_ff <= bsh_x_ff + ofs_x_ff;
            pz_ff <= bsh_z_ff + ofs_z_ff;
         end
         fbm_pkg::OP_P1: begin
            hx_ff  <= ix * fbm_pkg::HASH_CX;
            hz_ff  <= iz * fbm_pkg::HASH_CZ;
            hs_ff  <= seed_o_ff * fbm_pkg::HASH_CS;
            tx2_ff <= sqx[47:24];
            tz2_ff <= sqz[47:24];
         end
         fbm_pkg::OP_P2: begin
            for (int i = 0; i < 4; i++) begin
               m1_ff[i] <= v1[i] * fbm_pkg::MIX_M1;
            end
            fx_ff <= fpx[47:24];
            fz_ff <= fpz[47:24];
         end
         fbm_pkg::OP_P3: begin
            for (int i = 0; i < 4; i++) begin
               m2_ff[i] <= v2[i] * fbm_pkg::MIX_M2;
            end
         end
         fbm_pkg::OP_P4: begin
            a_ff <= lerp_a[47:24];
            b_ff <= lerp_b[47:24];
         end
         fbm_pkg::OP_P5: begin
            sum_ff    <= {sum_ff[SW-2:0], 1'b0} + SW'(lerp_n[47:24]);
            bsh_x_ff  <= {bsh_x_ff[62:0], 1'b0};
            bsh_z_ff  <= {bsh_z_ff[62:0], 1'b0};
            ofs_x_ff  <= ofs_x_ff + fbm_pkg::OFS_X;
            ofs_z_ff  <= ofs_z_ff + fbm_pkg::OFS_Z;
            seed_o_ff <= seed_o_ff + fbm_pkg::SEED_STEP;
         end
         fbm_pkg::OP_DIVSTEP: begin
            rem_ff <= ge ? rem_dif[MO-1:0] : rem_sh[MO-1:0];
            sum_ff <= {sum_ff[SW-2:0], ge};
         end
         fbm_pkg::OP_SHP1: begin
            h_ff   <= hq;
            t2h_ff <= sqh[47:24];
         end
         fbm_pkg::OP_SHP2: begin
            shaped_ff <= fph[47:24];
         end
         fbm_pkg::OP_OUT:  height_ff <= scl[39:16];
         fbm_pkg::OP_ZERO: height_ff <= '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.op == fbm_pkg::OP_OUT || cmd.op == fbm_pkg::OP_ZERO) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_height      = height_ff;
   assign status.oct_num  = k_eff;
   assign status.out_free = !valid_ff || rsp_ready;

endmodule

/* rtl/fbm_value_noise_height.sv */
// Octave count zero goes straight to the output step and yields a zero height; otherwise
// K octaves run a base step, then the per-octave steps through the shared
// hash/fade/lerp unit, the bit-serial normalizing divider and the shaping/out steps.
// One sample in flight; the next is accepted the cycle after the result is written.
// Synchronous active-high reset clears control and restores register defaults.
module fbm_value_noise_height (
   input  logic             clock,
   input  logic             reset,
   fbm_req_if.sink          req_bus,
   fbm_rsp_if.source        rsp_bus,
   fbm_csr_if.sink          csr_bus
);

   fbm_pkg::cmd_type    cmd;
   fbm_pkg::status_type status;
   logic                req_ready;

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   fbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fbm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_world_x (req_bus.world_x),
      .req_world_z (req_bus.world_z),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_height  (rsp_bus.height),
      .csr_valid   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data)
   );

endmodule

/* rtl/fbm_chk.sv */
// Port-level checker for the height sampler, bound to the top level.
// Depends on the top level's interface ports only.
module fbm_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_height
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_height))
      else $error("response payload changed while stalled");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after request");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fbm_value_noise_height fbm_chk u_fbm_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_height (rsp_bus.height)
);

/* test/fbm_value_noise_height_tb.sv */
// Testbench for fbm_value_noise_height: drives coordinate beats, predicts each
// height in fixed point and checks the responses in order across register settings.
// Depends on fbm_pkg and the channel interfaces in fbm_if.sv.
module fbm_value_noise_height_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int SETTLE       = 100;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] z;
   } coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fbm_req_if req_if();
   fbm_rsp_if rsp_if();
   fbm_csr_if csr_if();

   fbm_value_noise_height dut (
      .clock(clock), .reset(reset),
      .req_bus(req_if), .rsp_bus(rsp_if), .csr_bus(csr_if)
   );

   logic [23:0] freq_q;
   logic [3:0]  oct_q;
   logic [31:0] seed_q;
   logic [15:0] scale_q;

   coord_type   coord_q[$];
   logic [23:0] height_q[$];
   coord_type   cur;
   int          errors = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   bit          idle_on = 1'b1;
   bit          long_hold = 1'b0;
   int          cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0; req_if.world_x = '0; req_if.world_z = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0; csr_if.index = '0; csr_if.data = '0;
   end

   function automatic logic [23:0] smooth(logic [23:0] t);
      logic [63:0] t2, k;
      t2 = (64'(t) * 64'(t)) >> 24;
      k  = 64'h300_0000 - 2 * 64'(t);
      return 24'((t2 * k) >> 24);
   endfunction

   function automatic logic [23:0] blend(logic [23:0] a, logic [23:0] b, logic [23:0] f);
      logic [63:0] r;
      r = 64'(a) * (64'h100_0000 - 64'(f)) + 64'(b) * 64'(f);
      return 24'(r >> 24);
   endfunction

   function automatic logic [23:0] lattice(logic [31:0] cx, logic [31:0] cz, logic [31:0] s);
      logic [31:0] v;
      v = (cx * 32'd73856093) ^ (cz * 32'd19349663) ^ (s * 32'd83492791);
      v = v ^ (v >> 16); v = v * 32'h7feb352d;
      v = v ^ (v >> 15); v = v * 32'h846ca68b;
      v = v ^ (v >> 16);
      return v[23:0];
   endfunction

   function automatic logic [23:0] terrain_height(coord_type c);
      int          k;
      longint      fq;
      logic [63:0] bx, bz, px, pz, sum, h;
      logic [31:0] ix, iz, s;
      logic [23:0] fx, fz, a, b, sh;
      k = (oct_q > 8) ? 8 : oct_q;
      if (k == 0) return 24'd0;
      fq  = freq_q;
      bx  = longint'(c.x) * fq;
      bz  = longint'(c.z) * fq;
      sum = 0;
      for (int o = 0; o < k; o++) begin
         px = (bx << o) + 64'(o) * 64'h11_2147AE14;
         pz = (bz << o) + 64'(o) * 64'h1F_B5C28F5C;
         ix = px[63:32]; iz = pz[63:32];
         fx = smooth(px[31:8]); fz = smooth(pz[31:8]);
         s  = seed_q + 32'(o) * 32'd101;
         a  = blend(lattice(ix, iz, s), lattice(ix + 1, iz, s), fx);
         b  = blend(lattice(ix, iz + 1, s), lattice(ix + 1, iz + 1, s), fx);
         sum = sum + (64'(blend(a, b, fz)) << (k - 1 - o));
      end
      h = sum / ((64'd1 << k) - 1);
      if (h > 64'hFF_FFFF) h = 64'hFF_FFFF;
      sh = smooth(h[23:0]);
      return 24'((64'(sh) * 64'(scale_q)) >> 16);
   endfunction

   task automatic report(string what, logic [23:0] got, logic [23:0] want);
      errors++;
      $display("mismatch %s: height got %h want %h at cycle %0d", what, got, want, cycles);
   endtask

   // request driver
   always @(posedge clock) begin
      bit nv;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         nv = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            height_q.insert(height_q.size(), terrain_height(cur));
            nv = 1'b0;
         end
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (coord_q.size() > 0) begin
               cur = coord_q.pop_front();
               nv = 1'b1;
               req_if.world_x <= cur.x;
               req_if.world_z <= cur.z;
               if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 19);
            end
         end
         req_if.valid <= nv;
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (height_q.size() == 0) begin
               report("unexpected beat", rsp_if.height, 24'd0);
            end else begin
               want = height_q.pop_front();
               if (rsp_if.height !== want) report("height", rsp_if.height, want);
            end
         end
         if (rsp_gap > 0) rsp_gap--;
         else if (idle_on && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 19);
         rsp_if.ready <= !long_hold && rsp_gap == 0;
      end
   end

   // register model follows accepted writes
   always @(posedge clock) begin
      if (reset) begin
         freq_q <= fbm_pkg::NOISE_FREQ_RST; oct_q <= fbm_pkg::OCTAVE_COUNT_RST;
         seed_q <= fbm_pkg::NOISE_SEED_RST; scale_q <= fbm_pkg::HEIGHT_SCALE_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            fbm_pkg::CSR_NOISE_FREQ:   freq_q <= csr_if.data[23:0];
            fbm_pkg::CSR_OCTAVE_COUNT: oct_q <= csr_if.data[3:0];
            fbm_pkg::CSR_NOISE_SEED:   seed_q <= csr_if.data;
            fbm_pkg::CSR_HEIGHT_SCALE: scale_q <= csr_if.data[15:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("** fbm_value_noise_height: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(logic [7:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      wait (coord_q.size() == 0 && !req_if.valid && height_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add(logic [31:0] x, logic [31:0] z);
      coord_type c;
      c.x = x; c.z = z;
      coord_q.insert(coord_q.size(), c);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: add($urandom, $urandom);
            1: add($urandom_range(0, 32'h7F_FFFF) - 32'h40_0000,
                   $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000);
            default: add($urandom_range(0, 32'h3_FFFF) - 32'h2_0000, $urandom);
         endcase
      end
   endtask

   initial begin
      logic [31:0] vals[8];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
               32'h1, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
      for (int i = 0; i < 8; i++) add(vals[i], vals[7 - i]);
      add(32'h0000_8000, 32'h0000_8000);
      drain();
      csr_write(fbm_pkg::CSR_OCTAVE_COUNT, 32'd0);
      add(32'h7FFF_FFFF, 32'h8000_0000); add(32'h1234_5678, 32'h0);
      drain();
      csr_write(fbm_pkg::CSR_OCTAVE_COUNT, 32'hFFFF_FFF8);
      csr_write(fbm_pkg::CSR_NOISE_FREQ, 32'hFFFF_FFFF);
      csr_write(fbm_pkg::CSR_NOISE_SEED, 32'hFFFF_FFFF);
      csr_write(fbm_pkg::CSR_HEIGHT_SCALE, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) add(vals[i], vals[i + 2]);
      drain();
      csr_write(fbm_pkg::CSR_OCTAVE_COUNT, 32'd15);
      csr_write(fbm_pkg::CSR_NOISE_FREQ, 32'd0);
      csr_write(fbm_pkg::CSR_HEIGHT_SCALE, 32'd0);
      csr_write(8'd4, 32'hFFFF_FFFF);
      csr_write(8'hFF, 32'h0);
      add(vals[1], vals[2]); add(vals[3], vals[5]);
      drain();
      for (int p = 0; p < 10; p++) begin
         csr_write(fbm_pkg::CSR_NOISE_FREQ,
                   (p % 3 == 0) ? $urandom : $urandom_range(0, 32'h4_0000));
         csr_write(fbm_pkg::CSR_OCTAVE_COUNT, (p == 2) ? 32'd1 : $urandom_range(0, 9));
         csr_write(fbm_pkg::CSR_NOISE_SEED, $urandom);
         csr_write(fbm_pkg::CSR_HEIGHT_SCALE, $urandom);
         if (p == 9) idle_on = 1'b0;
         add_random(170);
         if (p == 4) begin
            long_hold = 1'b1;
            repeat (600) @(posedge clock);
            long_hold = 1'b0;
         end
         drain();
      end
      if (errors == 0) begin
         $display("** fbm_value_noise_height: PASSED **");
      end else begin
         $display("** fbm_value_noise_height: FAILED **");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/fbm_pkg.sv
rtl/fbm_if.sv
rtl/fbm_ctrl.sv
rtl/fbm_dp.sv
rtl/fbm_value_noise_height.sv
rtl/fbm_chk.sv
test/fbm_value_noise_height_tb.sv
